// ===== sv/tfd_pkg.sv =====
// shared types, constants and helper functions for the texel format decoder
package tfd_pkg;

  // fixed field widths
  localparam int unsigned TEXEL_W   = 32;
  localparam int unsigned PAL_W     = 16;
  localparam int unsigned PIDX_W    = 8;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned DIM_W     = 8;
  localparam int unsigned PCOUNT_W  = 9;
  localparam int unsigned FMT_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 9;

  // parameter defaults
  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned MAX_DIM_DEF       = 256;

  // operation codes of an input item
  typedef enum logic {
    OP_DECODE    = 1'b0,
    OP_PAL_WRITE = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXEL_FORMAT  = 2'd0,
    CFG_PALETTE_COUNT = 2'd1,
    CFG_IMAGE_WIDTH   = 2'd2,
    CFG_IMAGE_HEIGHT  = 2'd3
  } cfg_idx_t;

  // texel format codes
  typedef enum logic [FMT_W-1:0] {
    FMT_RGBA32    = 4'd0,
    FMT_RGBA16    = 4'd1,
    FMT_RGB24     = 4'd2,
    FMT_RGB15     = 4'd3,
    FMT_IA16      = 4'd4,
    FMT_IA8       = 4'd5,
    FMT_IA4       = 4'd6,
    FMT_I8        = 4'd7,
    FMT_I4        = 4'd8,
    FMT_CI8_RGBA  = 4'd9,
    FMT_CI4_RGBA  = 4'd10,
    FMT_CI8_IA    = 4'd11,
    FMT_CI4_IA    = 4'd12
  } fmt_t;

  // decoded color
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  // decode item between the accept stage and the color stage
  typedef struct packed {
    fmt_t               fmt;
    logic [TEXEL_W-1:0] texel;
    logic [3:0]         nib;
    logic               ok;
    logic               bad;
    logic               last;
  } s1_t;

  // 3-bit intensity scaled to 8 bits (v * 255 / 7)
  function automatic logic [CHAN_W-1:0] ia4_scale(input logic [2:0] v);
    logic [CHAN_W-1:0] r;
    begin
      case (v)
        3'd0: r = 8'd0;
        3'd1: r = 8'd36;
        3'd2: r = 8'd72;
        3'd3: r = 8'd109;
        3'd4: r = 8'd145;
        3'd5: r = 8'd182;
        3'd6: r = 8'd218;
        default: r = 8'd255;
      endcase
      return r;
    end
  endfunction

  // 5:5:5:1 word to 8-bit channels
  function automatic rgba_t from_rgba16(input logic [PAL_W-1:0] w);
    rgba_t c;
    begin
      c.red   = {w[15:11], 3'b000};
      c.green = {w[10:6], 3'b000};
      c.blue  = {w[5:1], 3'b000};
      c.alpha = w[0] ? 8'hFF : 8'h00;
      return c;
    end
  endfunction

  // intensity/alpha word to 8-bit channels
  function automatic rgba_t from_ia16(input logic [PAL_W-1:0] w);
    rgba_t c;
    begin
      c.red   = w[15:8];
      c.green = w[15:8];
      c.blue  = w[15:8];
      c.alpha = w[7:0];
      return c;
    end
  endfunction

endpackage

// ===== sv/texel_format_decoder_unit.sv =====
// texel format decoder top level: counters, palette access and color conversion
// Accepted items pass the first stage (palette read), then the color stage.
// One item per cycle unless a stalled output backs up both stages; palette writes
// and decodes may interleave freely. The palette RAM read is registered.
// Reset clears configuration, counters, error flag and valid bits; the palette
// RAM is not cleared and holds undefined data until written.
module texel_format_decoder_unit #(
  parameter int unsigned PALETTE_DEPTH = tfd_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_DIM       = tfd_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [tfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfd_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [tfd_pkg::TEXEL_W-1:0]   in_texel_bits,
  input  logic [tfd_pkg::PIDX_W-1:0]    in_palette_index,
  input  logic [tfd_pkg::PAL_W-1:0]     in_palette_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tfd_pkg::CHAN_W-1:0]    out_red,
  output logic [tfd_pkg::CHAN_W-1:0]    out_green,
  output logic [tfd_pkg::CHAN_W-1:0]    out_blue,
  output logic [tfd_pkg::CHAN_W-1:0]    out_alpha,
  output logic                          out_image_bad,
  output logic                          out_last_of_image
);
  import tfd_pkg::*;

  localparam int unsigned PAL_AW = $clog2(PALETTE_DEPTH);
  localparam logic [PCOUNT_W-1:0] DEPTH_LIM = PCOUNT_W'(PALETTE_DEPTH);
  localparam logic [DIM_W:0]      DIM_LIM   = (DIM_W + 1)'(MAX_DIM);

  // configuration registers
  fmt_t                fmt_r;
  logic [PCOUNT_W-1:0] pcount_r;
  logic [DIM_W-1:0]    width_r;
  logic [DIM_W-1:0]    height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_RGBA32;
      pcount_r <= '0;
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEXEL_FORMAT:  fmt_r    <= fmt_t'(cfg_data[FMT_W-1:0]);
        CFG_PALETTE_COUNT: pcount_r <= cfg_data[PCOUNT_W-1:0];
        CFG_IMAGE_WIDTH:   width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_load, s1_adv, in_acc, dec_acc, pal_acc;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_load;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;
  assign dec_acc  = in_acc && (op_t'(in_operation) == OP_DECODE);
  assign pal_acc  = in_acc && (op_t'(in_operation) == OP_PAL_WRITE);

  // image walk state
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic             err_r, err_nxt;

  // accept stage: nibble, palette index check, row and image end
  logic [PIDX_W-1:0] byte_v;
  logic [3:0]        nib;
  logic [PIDX_W-1:0] ci;
  logic              ci_ok;
  logic              ok;
  logic [DIM_W:0]    col_inc, row_inc;
  logic              row_end, last;
  s1_t               s1_in;

  always_comb begin
    byte_v = in_texel_bits[PIDX_W-1:0];
    nib    = col_r[0] ? byte_v[3:0] : byte_v[7:4];
    ci     = byte_v;
    if ((fmt_r == FMT_CI4_RGBA) || (fmt_r == FMT_CI4_IA)) begin
      ci = {4'b0000, nib};
    end
    ci_ok = ({1'b0, ci} < pcount_r) && ({1'b0, ci} < DEPTH_LIM);
    unique case (fmt_r)
      FMT_RGBA32, FMT_RGBA16, FMT_RGB24, FMT_RGB15, FMT_IA16, FMT_IA8,
      FMT_IA4, FMT_I8, FMT_I4: ok = 1'b1;
      FMT_CI8_RGBA, FMT_CI4_RGBA, FMT_CI8_IA, FMT_CI4_IA: ok = ci_ok;
      default: ok = 1'b0;
    endcase
    col_inc = {1'b0, col_r} + (DIM_W + 1)'(1);
    row_inc = {1'b0, row_r} + (DIM_W + 1)'(1);
    row_end = (col_inc >= {1'b0, width_r}) || (col_inc >= DIM_LIM);
    last    = row_end && ((row_inc >= {1'b0, height_r}) || (row_inc >= DIM_LIM));

    s1_in.fmt   = fmt_r;
    s1_in.texel = in_texel_bits;
    s1_in.nib   = nib;
    s1_in.ok    = ok;
    s1_in.bad   = err_r || !ok;
    s1_in.last  = last;

    col_nxt = col_r;
    row_nxt = row_r;
    err_nxt = err_r;
    if (dec_acc) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
        err_nxt = 1'b0;
      end else begin
        err_nxt = err_r || !ok;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_inc[DIM_W-1:0];
        end else begin
          col_nxt = col_inc[DIM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      err_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      err_r <= err_nxt;
    end
  end

  // palette memory; writes beyond the depth are dropped
  logic             pal_we;
  logic [PAL_W-1:0] pal_rdata;

  assign pal_we = pal_acc && ({1'b0, in_palette_index} < DEPTH_LIM);

  tfd_palette_ram #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_palette_index[PAL_AW-1:0]),
    .wdata (in_palette_word),
    .re    (dec_acc),
    .raddr (ci[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  // first stage register
  s1_t s1_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = dec_acc;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_acc) begin
      s1_r <= s1_in;
    end
  end

  // color stage
  rgba_t color;
  logic [CHAN_W-1:0] b1;

  always_comb begin
    b1 = s1_r.texel[CHAN_W-1:0];
    color = '{red: '0, green: '0, blue: '0, alpha: 8'hFF};
    unique case (s1_r.fmt)
      FMT_RGBA32: begin
        color = '{red: s1_r.texel[31:24], green: s1_r.texel[23:16],
                  blue: s1_r.texel[15:8], alpha: s1_r.texel[7:0]};
      end
      FMT_RGB24: begin
        color = '{red: s1_r.texel[31:24], green: s1_r.texel[23:16],
                  blue: s1_r.texel[15:8], alpha: 8'hFF};
      end
      FMT_RGBA16: color = from_rgba16(s1_r.texel[PAL_W-1:0]);
      FMT_RGB15: begin
        color       = from_rgba16(s1_r.texel[PAL_W-1:0]);
        color.alpha = 8'hFF;
      end
      FMT_IA16: color = from_ia16(s1_r.texel[PAL_W-1:0]);
      FMT_IA8: begin
        color = '{red: {b1[7:4], b1[7:4]}, green: {b1[7:4], b1[7:4]},
                  blue: {b1[7:4], b1[7:4]}, alpha: {b1[3:0], b1[3:0]}};
      end
      FMT_IA4: begin
        color.red   = ia4_scale(s1_r.nib[3:1]);
        color.green = ia4_scale(s1_r.nib[3:1]);
        color.blue  = ia4_scale(s1_r.nib[3:1]);
        color.alpha = s1_r.nib[0] ? 8'hFF : 8'h00;
      end
      FMT_I8: color = '{red: b1, green: b1, blue: b1, alpha: 8'hFF};
      FMT_I4: begin
        color = '{red: {s1_r.nib, s1_r.nib}, green: {s1_r.nib, s1_r.nib},
                  blue: {s1_r.nib, s1_r.nib}, alpha: 8'hFF};
      end
      FMT_CI8_RGBA, FMT_CI4_RGBA: color = from_rgba16(pal_rdata);
      FMT_CI8_IA, FMT_CI4_IA:     color = from_ia16(pal_rdata);
      default: color = '0;
    endcase
    if (!s1_r.ok) begin
      color = '0;
    end
  end

  // output register
  rgba_t out_color_r;
  logic  out_bad_r, out_last_r;

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_color_r <= color;
      out_bad_r   <= s1_r.bad;
      out_last_r  <= s1_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_color_r.red;
  assign out_green         = out_color_r.green;
  assign out_blue          = out_color_r.blue;
  assign out_alpha         = out_color_r.alpha;
  assign out_image_bad     = out_bad_r;
  assign out_last_of_image = out_last_r;

  // a palette write never occupies the color stage
  a_pal_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    pal_acc |=> !s1_valid_r)
    else $error("palette write produced a pipeline item");

  // the walk state clears after the last texel of an image
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_acc && last) |=> (col_r == '0) && (row_r == '0) && !err_r)
    else $error("counters or error flag not cleared after last texel");

  // input only stalls when both stages hold items
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // a stalled result is not overwritten by the color stage
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_color_r))
    else $error("pending result overwritten");

endmodule

// ===== sv/tfd_palette_ram.sv =====
// palette memory: one write port, one registered read port
module tfd_palette_ram #(
  parameter int unsigned DEPTH = tfd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [tfd_pkg::PAL_W-1:0]  wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [tfd_pkg::PAL_W-1:0]  rdata
);
  import tfd_pkg::*;

  logic [PAL_W-1:0] mem [DEPTH];
  logic [PAL_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while no read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
